// ----- hdl/pcsc_pkg.sv -----
`timescale 1ns / 1ps

package pcsc_pkg;

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IEND    = 3'd1,
    ST_BAD_SIG = 3'd2,
    ST_BAD_CRC = 3'd3,
    ST_TRUNC   = 3'd4
  } status_e;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] KIND_IHDR = 32'h4948_4452;
  localparam logic [31:0] KIND_IEND = 32'h4945_4E44;

  localparam logic [7:0] SIG_BYTES [8] = '{
    8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
  };

  typedef struct packed {
    phase_e      phase;
    logic [31:0] fcnt;
    logic        sig_ok;
    logic [31:0] len;
    logic [31:0] kind;
    logic [31:0] stored;
    logic [31:0] crc;
    logic [31:0] acc;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  depth;
    logic [7:0]  colour;
    logic [31:0] pend_w;
    logic [31:0] pend_h;
    logic [7:0]  pend_d;
    logic [7:0]  pend_c;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:  PH_SIG,
    fcnt:   32'd0,
    sig_ok: 1'b1,
    len:    32'd0,
    kind:   32'd0,
    stored: 32'd0,
    crc:    ALL_ONES,
    acc:    32'd0,
    width:  32'd0,
    height: 32'd0,
    depth:  8'd0,
    colour: 8'd0,
    pend_w: 32'd0,
    pend_h: 32'd0,
    pend_d: 8'd0,
    pend_c: 8'd0
  };

  // Reflected CRC-32 update over one byte, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/pcsc_stream_if.sv -----
`timescale 1ns / 1ps

interface pcsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  logic       file_end;

  modport source (output valid, data_byte, file_start, file_end, input ready);
  modport sink (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface pcsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] chunk_number;
  logic [31:0] chunk_kind;
  logic [31:0] chunk_bytes;
  logic [31:0] chunk_check;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [7:0]  bit_depth;
  logic [7:0]  color_kind;

  modport source (
    output valid, status, chunk_number, chunk_kind, chunk_bytes, chunk_check,
           image_width, image_height, bit_depth, color_kind,
    input  ready
  );
  modport sink (
    input  valid, status, chunk_number, chunk_kind, chunk_bytes, chunk_check,
           image_width, image_height, bit_depth, color_kind,
    output ready
  );
endinterface

// ----- hdl/png_chunk_stream_checker_core.sv -----
`timescale 1ns / 1ps

// PNG chunk stream checker. Takes one file byte per beat and accepts a new beat
// every clock cycle unless a result waits unread at the output; a result beat for
// the byte that completes a chunk passes the input register, then parsing and the
// CRC-32 update into the result register. The one-byte CRC update is the longest
// path and sets the rate of one byte per cycle. A waiting result holds the parse
// stage, so a byte enters the input register only while it is empty. file_start
// on a byte restarts the parse from that byte; after an IEND, a bad signature, a
// CRC mismatch or an early file end, bytes are dropped until the next file_start.
module png_chunk_stream_checker_core (
  input  logic clk_i,
  input  logic rst_ni,
  pcsc_in_if.sink    in_i,
  pcsc_out_if.source out_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       in_end_q;

  // Parse state
  pcsc_pkg::state_t state_q, state_d;

  // Result register
  logic              out_valid_q;
  pcsc_pkg::status_e out_status_q, status_d;
  pcsc_pkg::state_t  out_snap_q, snap_d;

  logic        stage_go;
  logic        stage_fire;
  logic        have_d;
  logic [31:0] fc_inc;

  assign stage_go   = !out_valid_q || out_o.ready;
  assign stage_fire = stage_go && in_valid_q;
  assign in_i.ready = !in_valid_q || stage_go;

  always_comb begin
    state_d  = in_start_q ? pcsc_pkg::STATE_RESET : state_q;
    have_d   = 1'b0;
    status_d = pcsc_pkg::ST_OK;
    fc_inc   = state_d.fcnt + 32'd1;

    unique case (state_d.phase)
      pcsc_pkg::PH_SIG: begin
        if (in_byte_q != pcsc_pkg::SIG_BYTES[state_d.fcnt[2:0]]) begin
          state_d.sig_ok = 1'b0;
        end
        state_d.fcnt = fc_inc;
        if (fc_inc == 32'd8) begin
          state_d.fcnt = 32'd0;
          if (!state_d.sig_ok) begin
            have_d        = 1'b1;
            status_d      = pcsc_pkg::ST_BAD_SIG;
            state_d.phase = pcsc_pkg::PH_DONE;
          end else begin
            state_d.phase = pcsc_pkg::PH_LEN;
          end
        end
      end
      pcsc_pkg::PH_LEN: begin
        state_d.len  = {state_d.len[23:0], in_byte_q};
        state_d.fcnt = fc_inc;
        if (fc_inc == 32'd4) begin
          state_d.fcnt  = 32'd0;
          state_d.crc   = pcsc_pkg::ALL_ONES;
          state_d.phase = pcsc_pkg::PH_TYPE;
        end
      end
      pcsc_pkg::PH_TYPE: begin
        state_d.kind = {state_d.kind[23:0], in_byte_q};
        state_d.crc  = pcsc_pkg::crc_byte(state_d.crc, in_byte_q);
        state_d.fcnt = fc_inc;
        if (fc_inc == 32'd4) begin
          state_d.fcnt   = 32'd0;
          state_d.pend_w = 32'd0;
          state_d.pend_h = 32'd0;
          state_d.pend_d = 8'd0;
          state_d.pend_c = 8'd0;
          state_d.phase  = (state_d.len != 32'd0) ? pcsc_pkg::PH_DATA : pcsc_pkg::PH_CRC;
        end
      end
      pcsc_pkg::PH_DATA: begin
        state_d.crc = pcsc_pkg::crc_byte(state_d.crc, in_byte_q);
        // The first ten IHDR data bytes hold width, height, depth and colour type.
        if (state_d.kind == pcsc_pkg::KIND_IHDR && state_d.fcnt < 32'd10) begin
          priority if (state_d.fcnt[3:0] < 4'd4) begin
            state_d.pend_w |= {24'd0, in_byte_q} << {(2'd3 - state_d.fcnt[1:0]), 3'b000};
          end else if (state_d.fcnt[3:0] < 4'd8) begin
            state_d.pend_h |= {24'd0, in_byte_q} << {(2'd3 - state_d.fcnt[1:0]), 3'b000};
          end else if (state_d.fcnt[3:0] == 4'd8) begin
            state_d.pend_d = in_byte_q;
          end else begin
            state_d.pend_c = in_byte_q;
          end
        end
        state_d.fcnt = fc_inc;
        if (fc_inc == state_d.len) begin
          state_d.fcnt  = 32'd0;
          state_d.phase = pcsc_pkg::PH_CRC;
        end
      end
      pcsc_pkg::PH_CRC: begin
        state_d.stored = {state_d.stored[23:0], in_byte_q};
        state_d.fcnt   = fc_inc;
        if (fc_inc == 32'd4) begin
          state_d.fcnt = 32'd0;
          have_d       = 1'b1;
          if ((state_d.crc ^ pcsc_pkg::ALL_ONES) != state_d.stored) begin
            status_d      = pcsc_pkg::ST_BAD_CRC;
            state_d.phase = pcsc_pkg::PH_DONE;
          end else begin
            if (state_d.acc != pcsc_pkg::ALL_ONES) begin
              state_d.acc = state_d.acc + 32'd1;
            end
            if (state_d.kind == pcsc_pkg::KIND_IEND) begin
              status_d      = pcsc_pkg::ST_IEND;
              state_d.phase = pcsc_pkg::PH_DONE;
            end else begin
              if (state_d.kind == pcsc_pkg::KIND_IHDR) begin
                state_d.width  = state_d.pend_w;
                state_d.height = state_d.pend_h;
                state_d.depth  = state_d.pend_d;
                state_d.colour = state_d.pend_c;
              end
              status_d      = pcsc_pkg::ST_OK;
              state_d.phase = pcsc_pkg::PH_LEN;
            end
          end
        end
      end
      pcsc_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (in_end_q && state_d.phase != pcsc_pkg::PH_DONE) begin
      have_d        = 1'b1;
      status_d      = pcsc_pkg::ST_TRUNC;
      state_d.phase = pcsc_pkg::PH_DONE;
    end

    // The result shows the chunk fields before they are cleared for the next chunk.
    snap_d = state_d;
    if (have_d && state_d.phase == pcsc_pkg::PH_LEN) begin
      state_d.len    = 32'd0;
      state_d.kind   = 32'd0;
      state_d.stored = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= pcsc_pkg::STATE_RESET;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (stage_go) begin
        out_valid_q <= in_valid_q && have_d;
      end
      if (stage_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.file_start;
      in_end_q   <= in_i.file_end;
    end
    if (stage_fire && have_d) begin
      out_status_q <= status_d;
      out_snap_q   <= snap_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.chunk_number = out_snap_q.acc;
  assign out_o.chunk_kind   = out_snap_q.kind;
  assign out_o.chunk_bytes  = out_snap_q.len;
  assign out_o.chunk_check  = out_snap_q.stored;
  assign out_o.image_width  = out_snap_q.width;
  assign out_o.image_height = out_snap_q.height;
  assign out_o.bit_depth    = out_snap_q.depth;
  assign out_o.color_kind   = out_snap_q.colour;

  // A new result beat only ever comes from a byte handled by the parse stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(stage_fire))
    else $error("result beat without a parsed byte");

  // Once the parse is finished, bytes without file_start give no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && !in_start_q && state_q.phase == pcsc_pkg::PH_DONE |-> !have_d)
    else $error("result after the parse had finished");

  // The chunk count only grows within one file.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && !in_start_q |-> state_d.acc >= state_q.acc)
    else $error("chunk count went down without a file start");

  // A bad signature is reported before any chunk is seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && have_d && status_d == pcsc_pkg::ST_BAD_SIG |->
      snap_d.acc == 32'd0 && snap_d.kind == 32'd0 && snap_d.len == 32'd0)
    else $error("bad signature result carries chunk fields");

endmodule
